// ===== hdl/ssr_pkg.sv =====
// shared types, constants and helper functions for the search-and-replace engine
package ssr_pkg;

  // sizes of the stores and of one character
  localparam int PATTERN_MAX = 16;
  localparam int REPLACE_MAX = 16;
  localparam int CHAR_BITS   = 16;
  localparam int LEN_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

  // derived widths
  localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
  localparam int LEN_W  = $clog2(LEN_MAX + 1);

  // fixed field widths of the ports
  localparam int TYPE_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int CODE_W  = 16;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX = 2;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // request codes
  localparam logic [TYPE_W-1:0] REQ_TEXT    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_PATTERN = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REPLACE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX-1:0] REG_PATTERN_LENGTH     = 2'd0;
  localparam logic [CFG_IDX-1:0] REG_REPLACEMENT_LENGTH = 2'd1;
  localparam logic [CFG_IDX-1:0] REG_IGNORE_CASE        = 2'd2;

  // work orders handed from front to back
  typedef enum logic [1:0] {
    CMD_CHARS    = 2'd0,
    CMD_REPL     = 2'd1,
    CMD_TERM     = 2'd2,
    CMD_LOAD_REP = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                               kind;
    logic                                    last;
    logic [LEN_W-1:0]                        count;
    logic [SLOT_W-1:0]                       slot;
    logic [PATTERN_MAX-1:0][CHAR_BITS-1:0]   chars;
  } cmd_t;

  // live configuration, lengths already clamped
  typedef struct packed {
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    logic             icase;
    logic             clear_window;
  } cfg_t;

  // ascii upper to lower fold
  function automatic logic [CHAR_BITS-1:0] fold_char(input logic [CHAR_BITS-1:0] c,
                                                     input logic icase);
    logic [CHAR_BITS-1:0] r;
    r = c;
    if (icase && c >= CHAR_BITS'(8'h41) && c <= CHAR_BITS'(8'h5A)) begin
      r = c + CHAR_BITS'(8'h20);
    end
    return r;
  endfunction

  // pattern length clamp: zero counts as one
  function automatic logic [LEN_W-1:0] clamp_plen(input logic [CFG_W-1:0] d);
    logic [LEN_W-1:0] r;
    if (d == '0) begin
      r = LEN_W'(1);
    end else if (int'(d) > PATTERN_MAX) begin
      r = LEN_W'(PATTERN_MAX);
    end else begin
      r = LEN_W'(d);
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_rlen(input logic [CFG_W-1:0] d);
    logic [LEN_W-1:0] r;
    if (int'(d) > REPLACE_MAX) begin
      r = LEN_W'(REPLACE_MAX);
    end else begin
      r = LEN_W'(d);
    end
    return r;
  endfunction

endpackage

// ===== hdl/ssr_front.sv =====
// front end: takes requests, keeps the pattern and text window, issues commands
module ssr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  ssr_pkg::cfg_t                 cfg,
  input  logic                          take,
  input  logic [ssr_pkg::TYPE_W-1:0]    req_type,
  input  logic [ssr_pkg::SLOT_W-1:0]    slot,
  input  logic [ssr_pkg::CODE_W-1:0]    char_code,
  input  logic                          end_of_text,
  output logic                          push,
  output ssr_pkg::cmd_t                 cmd
);
  import ssr_pkg::*;

  logic [CHAR_BITS-1:0] pat [PATTERN_MAX];
  logic [CHAR_BITS-1:0] win [PATTERN_MAX];
  logic [LEN_W-1:0]     fill;
  logic [LEN_W-1:0]     fill_next;

  logic [CHAR_BITS-1:0] ch;
  logic [CHAR_BITS-1:0] cand [PATTERN_MAX];
  logic [CHAR_BITS-1:0] shf  [PATTERN_MAX];
  logic                 full;
  logic                 match;
  logic                 is_text;

  assign ch      = CHAR_BITS'(char_code);
  assign is_text = take && (req_type == REQ_TEXT);

  // window with the new character placed, and parallel compare
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      cand[i] = (fill == LEN_W'(i)) ? ch : win[i];
    end
    for (int i = 0; i < PATTERN_MAX - 1; i++) begin
      shf[i] = cand[i + 1];
    end
    shf[PATTERN_MAX-1] = cand[PATTERN_MAX-1];
    full  = ((fill + LEN_W'(1)) == cfg.plen);
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < cfg.plen &&
          fold_char(cand[i], cfg.icase) != fold_char(pat[i], cfg.icase)) begin
        match = 1'b0;
      end
    end
  end

  // command decision and next fill level
  always_comb begin
    push      = 1'b0;
    cmd.kind  = CMD_CHARS;
    cmd.last  = end_of_text;
    cmd.count = LEN_W'(1);
    cmd.slot  = slot;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      cmd.chars[i] = cand[i];
    end
    fill_next = fill;
    if (cfg.clear_window) begin
      fill_next = '0;
    end else if (take) begin
      case (req_type)
        REQ_TEXT: begin
          if (full && match) begin
            fill_next = '0;
            cmd.count = cfg.rlen;
            if (cfg.rlen != '0) begin
              push     = 1'b1;
              cmd.kind = CMD_REPL;
            end else if (end_of_text) begin
              push     = 1'b1;
              cmd.kind = CMD_TERM;
            end
          end else if (full) begin
            push      = 1'b1;
            cmd.count = end_of_text ? cfg.plen : LEN_W'(1);
            fill_next = end_of_text ? '0 : cfg.plen - LEN_W'(1);
          end else begin
            fill_next = end_of_text ? '0 : fill + LEN_W'(1);
            if (end_of_text) begin
              push      = 1'b1;
              cmd.count = fill + LEN_W'(1);
            end
          end
        end
        REQ_REPLACE: begin
          push      = (int'(slot) < REPLACE_MAX);
          cmd.kind  = CMD_LOAD_REP;
          cmd.last  = 1'b0;
          cmd.chars[0] = ch;
        end
        default: begin
        end
      endcase
    end
  end

  // fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // pattern store and window contents
  always_ff @(posedge clk) begin
    if (take && req_type == REQ_PATTERN && int'(slot) < PATTERN_MAX) begin
      pat[PIDX_W'(slot)] <= ch;
    end
    if (is_text && !(full && match)) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win[i] <= full ? shf[i] : cand[i];
      end
    end
  end

endmodule

// ===== hdl/ssr_cmd_fifo.sv =====
// short command queue between front and back
module ssr_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ssr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output ssr_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import ssr_pkg::*;

  cmd_t              slots [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr;
  logic [FPTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FCNT_W'(FIFO_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == FIFO_DEPTH - 1) ? '0 : wr_ptr + FPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == FIFO_DEPTH - 1) ? '0 : rd_ptr + FPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + FCNT_W'(1);
        2'b01:   count <= count - FCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/ssr_back.sv =====
// back end: plays out commands one character per cycle into the output register unless stalled
module ssr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ssr_pkg::cmd_t                 head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssr_pkg::CODE_W-1:0]    out_char,
  output logic                          char_valid,
  output logic                          from_replacement,
  output logic                          last_of_text
);
  import ssr_pkg::*;

  logic [CHAR_BITS-1:0] rep [REPLACE_MAX];
  logic [LEN_W-1:0]     idx;
  logic                 room;
  logic                 at_end;
  logic                 emit;

  assign room   = !out_valid || !out_stall;
  assign at_end = ((idx + LEN_W'(1)) == head.count);
  assign emit   = !empty && room && (head.kind != CMD_LOAD_REP);

  // pop on a load, a terminator, or the last character of a run
  always_comb begin
    pop = 1'b0;
    if (!empty) begin
      case (head.kind)
        CMD_LOAD_REP: pop = 1'b1;
        CMD_TERM:     pop = room;
        CMD_CHARS:    pop = room && at_end;
        CMD_REPL:     pop = room && at_end;
        default:      pop = 1'b0;
      endcase
    end
  end

  // run position and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit && (head.kind == CMD_CHARS || head.kind == CMD_REPL)) begin
        idx <= at_end ? '0 : idx + LEN_W'(1);
      end
    end
  end

  // output payload and replacement store
  always_ff @(posedge clk) begin
    if (emit) begin
      case (head.kind)
        CMD_CHARS: begin
          out_char         <= CODE_W'(head.chars[PIDX_W'(idx)]);
          char_valid       <= 1'b1;
          from_replacement <= 1'b0;
          last_of_text     <= head.last && at_end;
        end
        CMD_REPL: begin
          out_char         <= CODE_W'(rep[RIDX_W'(idx)]);
          char_valid       <= 1'b1;
          from_replacement <= 1'b1;
          last_of_text     <= head.last && at_end;
        end
        default: begin
          out_char         <= '0;
          char_valid       <= 1'b0;
          from_replacement <= 1'b0;
          last_of_text     <= 1'b1;
        end
      endcase
    end
    if (!empty && head.kind == CMD_LOAD_REP) begin
      rep[RIDX_W'(head.slot)] <= head.chars[0];
    end
  end

endmodule

// ===== hdl/substring_search_replace.sv =====
// top level: configuration registers, front end, command queue and back end
// a text item's first result passes through the command queue and then the output register
// throughput: one input item per cycle while the queue is not full; back end plays one
// result character per cycle while the output is not stalled
// reset: clears window fill, queue and output valid; lengths return to 1 and 0, fold off
// pattern and replacement stores are not cleared and hold garbage until loaded
module substring_search_replace (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ssr_pkg::TYPE_W-1:0]     req_type,
  input  logic [ssr_pkg::SLOT_W-1:0]     slot,
  input  logic [ssr_pkg::CODE_W-1:0]     char_code,
  input  logic                           end_of_text,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ssr_pkg::CODE_W-1:0]     out_char,
  output logic                           char_valid,
  output logic                           from_replacement,
  output logic                           last_of_text,
  input  logic                           cfg_write,
  input  logic [ssr_pkg::CFG_IDX-1:0]    cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]      cfg_data
);
  import ssr_pkg::*;

  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  logic             icase;
  cfg_t             cfg;
  logic             take;
  logic             push;
  cmd_t             push_cmd;
  cmd_t             head;
  logic             empty;
  logic             full;
  logic             pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plen  <= LEN_W'(1);
      rlen  <= '0;
      icase <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LENGTH:     plen  <= clamp_plen(cfg_data);
        REG_REPLACEMENT_LENGTH: rlen  <= clamp_rlen(cfg_data);
        REG_IGNORE_CASE:        icase <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.plen         = plen;
  assign cfg.rlen         = rlen;
  assign cfg.icase        = icase;
  assign cfg.clear_window = cfg_write && (cfg_index == REG_PATTERN_LENGTH);

  // input transfer
  assign in_stall = full;
  assign take     = in_valid && !full;

  ssr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .req_type    (req_type),
    .slot        (slot),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .push        (push),
    .cmd         (push_cmd)
  );

  ssr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  ssr_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .char_valid       (char_valid),
    .from_replacement (from_replacement),
    .last_of_text     (last_of_text)
  );

endmodule

// ===== hdl/ssr_checker.sv =====
// port-level checks for the search-and-replace engine, bound to the top level
module ssr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ssr_pkg::CODE_W-1:0]  out_char,
  input logic                        char_valid,
  input logic                        from_replacement,
  input logic                        last_of_text
);
  import ssr_pkg::*;

  // a bare terminator is always the end of text and carries nothing
  a_bare_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> last_of_text && !from_replacement && out_char == '0)
    else $error("bare terminator malformed");

  // nothing leaves straight out of reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // queue is empty after reset so input is open
  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(char_valid)
      && $stable(from_replacement) && $stable(last_of_text))
    else $error("stalled result changed");

endmodule

bind substring_search_replace ssr_checker u_ssr_checker (.*);

// ===== bench/tb_top.sv =====
// self-checking testbench for the streaming find-and-replace engine
`timescale 1ns / 100ps

module tb_top;
  import ssr_pkg::*;

  // request code that the block must ignore
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 310;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic              eot;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] ch;
    logic              valid;
    logic              repl;
    logic              last;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TYPE_W-1:0] req_type = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic [CODE_W-1:0] char_code = '0;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CODE_W-1:0] out_char;
  logic char_valid;
  logic from_replacement;
  logic last_of_text;
  logic cfg_write = 1'b0;
  logic [CFG_IDX-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // stimulus and expectation stores
  req_t request_q[$];
  res_t rewritten_q[$];
  logic [CODE_W-1:0] pat_plan[16];
  int unsigned random_items = 0;
  int unsigned mismatches = 0;

  // predictor state
  logic [CODE_W-1:0] pat_mem[16];
  logic [CODE_W-1:0] rep_mem[16];
  logic [CODE_W-1:0] win_chars[16];
  int unsigned win_count = 0;
  logic [CFG_W-1:0] cfg_plen = 5'd1;
  logic [CFG_W-1:0] cfg_rlen = 5'd0;
  logic cfg_icase = 1'b0;

  // handshake bookkeeping between the edges
  req_t cur_req;
  bit holding = 1'b0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  int unsigned quiet_cycles = 0;

  substring_search_replace DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // effective lengths after clamping
  function automatic int unsigned pat_len_now();
    if (cfg_plen == 0) return 1;
    if (cfg_plen > 16) return 16;
    return cfg_plen;
  endfunction

  function automatic int unsigned rep_len_now();
    if (cfg_rlen > 16) return 16;
    return cfg_rlen;
  endfunction

  function automatic logic [CODE_W-1:0] fold_ascii(logic [CODE_W-1:0] c);
    if (cfg_icase && c >= 16'h0041 && c <= 16'h005A) return c + 16'h0020;
    return c;
  endfunction

  function automatic void shift_window();
    if (win_count == 0) return;
    for (int i = 0; i < 15; i++) win_chars[i] = win_chars[i + 1];
    win_chars[15] = '0;
    win_count--;
  endfunction

  // one accepted request: update the stores or slide the window
  function automatic void apply_request(req_t rq);
    res_t batch[$];
    int unsigned plen_n;
    int unsigned rlen_n;
    bit hit;
    case (rq.kind)
      REQ_PATTERN: pat_mem[rq.slot] = rq.code;
      REQ_REPLACE: rep_mem[rq.slot] = rq.code;
      REQ_TEXT: begin
        plen_n = pat_len_now();
        rlen_n = rep_len_now();
        while (win_count >= plen_n) shift_window();
        win_chars[win_count] = rq.code;
        win_count++;
        if (win_count == plen_n) begin
          hit = 1'b1;
          for (int i = 0; i < plen_n; i++) begin
            if (fold_ascii(win_chars[i]) != fold_ascii(pat_mem[i])) hit = 1'b0;
          end
          if (hit) begin
            for (int i = 0; i < rlen_n; i++) batch.push_back('{rep_mem[i], 1'b1, 1'b1, 1'b0});
            win_count = 0;
          end else begin
            batch.push_back('{win_chars[0], 1'b1, 1'b0, 1'b0});
            shift_window();
          end
        end
        // end of text flushes the window, or gives a bare terminator
        if (rq.eot) begin
          for (int i = 0; i < win_count; i++) batch.push_back('{win_chars[i], 1'b1, 1'b0, 1'b0});
          win_count = 0;
          if (batch.size() == 0) batch.push_back('{16'h0000, 1'b0, 1'b0, 1'b0});
          batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[k]) rewritten_q.push_back(batch[k]);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [CODE_W-1:0] want,
                                      logic [CODE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // input driver: one request held until its transfer
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (holding && in_took) holding = 1'b0;
      in_took = 1'b0;
      if (!holding && request_q.size() != 0) begin
        cur_req = request_q.pop_front();
        holding = 1'b1;
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 6);
      end
      if (holding && in_gap == 0) begin
        in_valid <= 1'b1;
        req_type <= cur_req.kind;
        slot <= cur_req.slot;
        char_code <= cur_req.code;
        end_of_text <= cur_req.eot;
      end else begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end
    end
  end

  // input transfer: predict what it causes
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      apply_request('{req_type, slot, char_code, end_of_text});
      in_took = 1'b1;
    end
  end

  // output back-pressure, drawn afresh after each transfer
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_took) begin
        out_took = 1'b0;
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 6);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // output transfer: compare with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      out_took = 1'b1;
      if (rewritten_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got char %h valid %b repl %b last %b",
                 $time, out_char, char_valid, from_replacement, last_of_text);
        mismatches++;
      end else begin
        want = rewritten_q.pop_front();
        check_field("out_char", want.ch, out_char);
        check_field("char_valid", 16'(want.valid), 16'(char_valid));
        check_field("from_replacement", 16'(want.repl), 16'(from_replacement));
        check_field("last_of_text", 16'(want.last), 16'(last_of_text));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("substring_search_replace regression: fail");
        $finish;
      end
    end
  end

  function automatic void queue_item(logic [TYPE_W-1:0] kind, logic [SLOT_W-1:0] sl,
                                     logic [CODE_W-1:0] code, logic eot);
    request_q.push_back('{kind, sl, code, eot});
    if (kind != REQ_UNUSED) random_items++;
  endfunction

  // mostly a and b in both cases, some near the letter ranges, some anything
  function automatic logic [CODE_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 16'h0041 + 16'($urandom_range(0, 1))
             + ($urandom_range(0, 1) ? 16'h0020 : 16'h0000);
    if (r < 85) return 16'($urandom_range(16'h003F, 16'h007C));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic bit is_letter(logic [CODE_W-1:0] c);
    return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
  endfunction

  // occasional loads and ignored requests between text characters
  function automatic void sprinkle_noise();
    int unsigned r;
    logic [SLOT_W-1:0] sl;
    r = $urandom_range(0, 99);
    sl = 4'($urandom);
    if (r < 4) begin
      pat_plan[sl] = pick_char();
      queue_item(REQ_PATTERN, sl, pat_plan[sl], 1'($urandom));
    end else if (r < 7) begin
      queue_item(REQ_REPLACE, sl, 16'($urandom), 1'($urandom));
    end else if (r < 10) begin
      queue_item(REQ_UNUSED, sl, 16'($urandom), 1'($urandom));
    end
  endfunction

  // text of about tlen characters, often carrying copies of the pattern
  function automatic void queue_text(int unsigned tlen, int unsigned plen_n, bit icase_w,
                                     bit closed);
    int unsigned done;
    bit near_miss;
    logic [CODE_W-1:0] c;
    done = 0;
    while (done < tlen) begin
      sprinkle_noise();
      if (tlen - done >= plen_n && $urandom_range(0, 99) < 40) begin
        near_miss = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < plen_n; k++) begin
          c = pat_plan[k];
          if (icase_w && is_letter(c) && $urandom_range(0, 1)) c = c ^ 16'h0020;
          if (near_miss && k == plen_n - 1) c = pick_char();
          done++;
          queue_item(REQ_TEXT, 4'($urandom), c, closed && done == tlen);
        end
      end else begin
        done++;
        queue_item(REQ_TEXT, 4'($urandom), pick_char(), closed && done == tlen);
      end
    end
  endfunction

  // wait until every request is in and every result is out, then let the block drain
  task automatic settle();
    while (request_q.size() != 0 || holding || rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PATTERN_LENGTH: begin
        cfg_plen = val;
        win_count = 0;
      end
      REG_REPLACEMENT_LENGTH: cfg_rlen = val;
      REG_IGNORE_CASE: cfg_icase = val[0];
      default: ;
    endcase
  endtask

  // one random phase: new settings, fresh stores, a few texts
  task automatic run_phase();
    int unsigned r;
    int unsigned plen_n;
    int unsigned rlen_n;
    int unsigned texts;
    logic [CFG_W-1:0] plen_w;
    logic [CFG_W-1:0] rlen_w;
    bit icase_w;
    bit open_end;
    r = $urandom_range(0, 99);
    if (r < 65) plen_w = 5'($urandom_range(1, 4));
    else if (r < 88) plen_w = 5'($urandom_range(5, 16));
    else if (r < 93) plen_w = 5'd0;
    else plen_w = 5'($urandom_range(17, 31));
    r = $urandom_range(0, 99);
    if (r < 10) rlen_w = 5'd0;
    else if (r < 70) rlen_w = 5'($urandom_range(1, 4));
    else if (r < 90) rlen_w = 5'($urandom_range(5, 16));
    else rlen_w = 5'($urandom_range(17, 31));
    icase_w = 1'($urandom_range(0, 1));
    settle();
    write_reg(REG_PATTERN_LENGTH, plen_w);
    write_reg(REG_REPLACEMENT_LENGTH, rlen_w);
    write_reg(REG_IGNORE_CASE, 5'(icase_w));
    plen_n = pat_len_now();
    rlen_n = rep_len_now();
    for (int i = 0; i < plen_n; i++) begin
      pat_plan[i] = pick_char();
      queue_item(REQ_PATTERN, 4'(i), pat_plan[i], 1'($urandom));
    end
    for (int i = 0; i < rlen_n; i++) queue_item(REQ_REPLACE, 4'(i), 16'($urandom), 1'($urandom));
    texts = $urandom_range(1, 4);
    // sometimes the last text stays open so the next length write drops the window
    open_end = ($urandom_range(0, 6) == 0);
    for (int t = 0; t < texts; t++)
      queue_text($urandom_range(1, 2 * plen_n + 4), plen_n, icase_w,
                 !(open_end && t == texts - 1));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every store entry written once so no comparison reads an unwritten entry
    for (int i = 0; i < 16; i++) begin
      pat_plan[i] = 16'($urandom);
      queue_item(REQ_PATTERN, 4'(i), pat_plan[i], 1'($urandom));
      queue_item(REQ_REPLACE, 4'(i), 16'($urandom), 1'($urandom));
    end

    // zero pattern length acts as one, oversized replacement clamps, fold on
    settle();
    write_reg(REG_PATTERN_LENGTH, 5'd0);
    write_reg(REG_REPLACEMENT_LENGTH, 5'd31);
    write_reg(REG_IGNORE_CASE, 5'd1);
    queue_item(REQ_PATTERN, 4'd0, 16'h0041, 1'b1);
    queue_item(REQ_TEXT, 4'd15, 16'h0061, 1'b0);
    queue_item(REQ_UNUSED, 4'd15, 16'hFFFF, 1'b1);
    queue_item(REQ_TEXT, 4'd0, 16'h0051, 1'b1);
    queue_item(REQ_PATTERN, 4'd0, 16'h007A, 1'b0);
    queue_item(REQ_TEXT, 4'd0, 16'h0040, 1'b0);
    queue_item(REQ_TEXT, 4'd0, 16'h005A, 1'b1);

    // extreme codes, match with empty replacement on the final character
    settle();
    write_reg(REG_PATTERN_LENGTH, 5'd2);
    write_reg(REG_REPLACEMENT_LENGTH, 5'd0);
    write_reg(REG_IGNORE_CASE, 5'd0);
    queue_item(REQ_PATTERN, 4'd0, 16'hFFFF, 1'b0);
    queue_item(REQ_PATTERN, 4'd1, 16'h0000, 1'b0);
    queue_item(REQ_TEXT, 4'd3, 16'h0000, 1'b0);
    queue_item(REQ_TEXT, 4'd3, 16'hFFFF, 1'b0);
    queue_item(REQ_TEXT, 4'd3, 16'h0000, 1'b1);
    queue_item(REQ_TEXT, 4'd3, 16'hFFFF, 1'b1);

    // a length write drops the characters held in the window
    settle();
    write_reg(REG_PATTERN_LENGTH, 5'd3);
    write_reg(REG_REPLACEMENT_LENGTH, 5'd16);
    queue_item(REQ_TEXT, 4'd0, 16'h0078, 1'b0);
    queue_item(REQ_TEXT, 4'd0, 16'h0079, 1'b0);
    settle();
    write_reg(REG_PATTERN_LENGTH, 5'd1);
    queue_item(REQ_TEXT, 4'd0, 16'h006B, 1'b1);

    // random phases
    random_items = 0;
    while (random_items < RANDOM_ITEMS) run_phase();

    settle();
    if (mismatches == 0) begin
      $display("substring_search_replace regression: pass");
    end else begin
      $display("substring_search_replace regression: fail");
    end
    $finish;
  end

endmodule
